@@ src/assert_macros.svh @@
// assertion macros used by the checker file
// expects clk_i and rst_ni in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is asserted
`define RHR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that also holds during reset
`define RHR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ src/rhr_pkg.sv @@
// shared constants and types for the rgb hue rotate pipeline
// no dependencies
`default_nettype none

package rhr_pkg;

  localparam int ChanW     = 8;
  localparam int StepsW    = 6;
  localparam int HsdW      = 9;
  localparam int GhostW    = 8;
  localparam int DataW     = 32;
  localparam int AddrW     = 3;

  localparam int DivDenW   = ChanW;
  localparam int DivQuoW   = 12;
  localparam int DivNumW   = DivDenW + DivQuoW;
  localparam int DivLanes  = 2;
  localparam int ShiftW    = 16;
  localparam int DivPayW   = ChanW + 2 + 1 + ShiftW;

  localparam int HueW      = 15;
  localparam int FracW     = 12;
  localparam int NumStages = 22;
  localparam int DivFirst  = 2;
  localparam int TailFirst = DivFirst + DivQuoW;

  localparam logic [ChanW-1:0]  CMax       = 8'd255;
  localparam logic [11:0]       SectorUnit = 12'd3840;
  localparam logic [HueW-1:0]   FullTurn   = 15'd23040;
  localparam logic [19:0]       PqtDen     = 20'd979200;
  localparam logic [19:0]       PqtHalf    = 20'd489600;
  localparam logic [20:0]       RecipPqt   = 21'd1122868;
  localparam logic [17:0]       RecipCmax  = 18'd131587;
  localparam logic [15:0]       Recip360   = 16'd46604;
  localparam logic [ShiftW-1:0] ShiftBias  = 16'd16560;
  localparam logic [8:0]        Degrees360 = 9'd360;

  localparam logic [HsdW-1:0]   HsdReset   = 9'd36;
  localparam logic [GhostW-1:0] GhostReset = 8'd26;

  typedef enum logic [AddrW-1:0] {
    REG_HUE_STEP = 3'h0,
    REG_GHOST    = 3'h4
  } reg_addr_e;

  typedef enum logic [1:0] {
    MAX_RED   = 2'd0,
    MAX_GREEN = 2'd1,
    MAX_BLUE  = 2'd2
  } max_chan_e;

endpackage

`default_nettype wire

@@ src/rhr_in_if.sv @@
// pixel input channel: valid, ready and the rgb plus hue step payload
// depends on rhr_pkg
`default_nettype none

interface rhr_in_if;
  logic                              valid;
  logic                              ready;
  logic [rhr_pkg::ChanW-1:0]         in_red;
  logic [rhr_pkg::ChanW-1:0]         in_green;
  logic [rhr_pkg::ChanW-1:0]         in_blue;
  logic signed [rhr_pkg::StepsW-1:0] hue_steps;

  modport source (output valid, in_red, in_green, in_blue, hue_steps, input ready);
  modport sink (input valid, in_red, in_green, in_blue, hue_steps, output ready);
endinterface

`default_nettype wire

@@ src/rhr_out_if.sv @@
// pixel output channel: valid, ready, rotated pixel and ghost colour
// depends on rhr_pkg
`default_nettype none

interface rhr_out_if;
  logic                      valid;
  logic                      ready;
  logic [rhr_pkg::ChanW-1:0] out_red;
  logic [rhr_pkg::ChanW-1:0] out_green;
  logic [rhr_pkg::ChanW-1:0] out_blue;
  logic [rhr_pkg::ChanW-1:0] ghost_red;
  logic [rhr_pkg::ChanW-1:0] ghost_green;
  logic [rhr_pkg::ChanW-1:0] ghost_blue;

  modport source (output valid, out_red, out_green, out_blue,
                  ghost_red, ghost_green, ghost_blue, input ready);
  modport sink (input valid, out_red, out_green, out_blue,
                ghost_red, ghost_green, ghost_blue, output ready);
endinterface

`default_nettype wire

@@ src/rhr_div.sv @@
// pipelined restoring divider, one quotient bit per stage, several lanes
// in lockstep with a side payload; stage enables come from the parent
`default_nettype none

module rhr_div #(
  parameter int DW    = rhr_pkg::DivDenW,
  parameter int QW    = rhr_pkg::DivQuoW,
  parameter int PW    = rhr_pkg::DivPayW,
  parameter int LANES = rhr_pkg::DivLanes
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [QW-1:0]                en_i,
  input  logic [LANES-1:0][DW+QW-1:0]  num_i,
  input  logic [LANES-1:0][DW-1:0]     den_i,
  input  logic [PW-1:0]                pay_i,
  output logic [QW-1:0]                vld_o,
  output logic [LANES-1:0][QW-1:0]     quo_o,
  output logic [PW-1:0]                pay_o
);

  localparam int NW = DW + QW;

  logic [QW-1:0]                vld_q;
  logic [LANES-1:0][NW-1:0]     w_q [QW];
  logic [LANES-1:0][DW-1:0]     d_q [QW];
  logic [PW-1:0]                p_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic                     v_src;
    logic [LANES-1:0][NW-1:0] w_src;
    logic [LANES-1:0][NW-1:0] w_d;
    logic [LANES-1:0][DW-1:0] d_src;
    logic [PW-1:0]            p_src;
    logic [LANES-1:0][DW:0]   part;
    logic [LANES-1:0][DW:0]   diff;

    if (k == 0) begin : g_head
      assign v_src = valid_i;
      assign w_src = num_i;
      assign d_src = den_i;
      assign p_src = pay_i;
    end else begin : g_body
      assign v_src = vld_q[k-1];
      assign w_src = w_q[k-1];
      assign d_src = d_q[k-1];
      assign p_src = p_q[k-1];
    end

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        part[l] = w_src[l][NW-1:QW-1];
        diff[l] = part[l] - {1'b0, d_src[l]};
        if (part[l] >= {1'b0, d_src[l]}) begin
          w_d[l] = {diff[l][DW-1:0], w_src[l][QW-2:0], 1'b1};
        end else begin
          w_d[l] = {part[l][DW-1:0], w_src[l][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i[k]) begin
        vld_q[k] <= v_src;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        w_q[k] <= w_d;
        d_q[k] <= d_src;
        p_q[k] <= p_src;
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quo_o[l] = w_q[QW-1][l][QW-1:0];
    end
  end

  assign vld_o = vld_q;
  assign pay_o = p_q[QW-1];

endmodule

`default_nettype wire

@@ src/rgb_hue_rotate.sv @@
// rgb hue rotation through hsv: one pixel per cycle sustained while the output is not
// stalled; the 12-stage saturation and hue divider sets the depth, a stalled output
// only holds the stages that are full
// asynchronous active-low reset empties the pipeline and sets step angle 36
// and ghost offset 26; depends on rhr_pkg, rhr_in_if, rhr_out_if, rhr_div
`default_nettype none

module rgb_hue_rotate (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  rhr_in_if.sink                          pix_i,
  rhr_out_if.source                       pix_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rhr_pkg::AddrW-1:0]       paddr,
  input  logic [rhr_pkg::DataW-1:0]       pwdata,
  output logic [rhr_pkg::DataW-1:0]       prdata,
  output logic                            pready
);

  localparam int CW = rhr_pkg::ChanW;
  localparam int NS = rhr_pkg::NumStages;
  localparam int DF = rhr_pkg::DivFirst;
  localparam int TF = rhr_pkg::TailFirst;
  localparam int QW = rhr_pkg::DivQuoW;
  localparam int NW = rhr_pkg::DivNumW;
  localparam int SW = rhr_pkg::ShiftW;
  localparam int HW = rhr_pkg::HueW;
  localparam int FW = rhr_pkg::FracW;

  // configuration
  logic [rhr_pkg::HsdW-1:0]   hsd_q;
  logic [rhr_pkg::GhostW-1:0] gof_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hsd_q <= rhr_pkg::HsdReset;
      gof_q <= rhr_pkg::GhostReset;
    end else if (psel && penable && pwrite) begin
      case (rhr_pkg::reg_addr_e'(paddr))
        rhr_pkg::REG_HUE_STEP: hsd_q <= pwdata[rhr_pkg::HsdW-1:0];
        rhr_pkg::REG_GHOST:    gof_q <= pwdata[rhr_pkg::GhostW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (rhr_pkg::reg_addr_e'(paddr))
      rhr_pkg::REG_HUE_STEP: prdata = rhr_pkg::DataW'(hsd_q);
      rhr_pkg::REG_GHOST:    prdata = rhr_pkg::DataW'(gof_q);
      default:               prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // stage valids and enables
  logic [NS-1:0]  vld;
  logic [NS-1:0]  en;
  logic [1:0]     f_vld_q;
  logic [QW-1:0]  div_vld;
  logic [NS-TF-2:0] t_vld_q;
  logic           o_vld_q;

  assign vld[DF-1:0]     = f_vld_q;
  assign vld[TF-1:DF]    = div_vld;
  assign vld[NS-2:TF]    = t_vld_q;
  assign vld[NS-1]       = o_vld_q;

  always_comb begin
    en[NS-1] = !vld[NS-1] || pix_o.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign pix_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= '0;
      t_vld_q <= '0;
      o_vld_q <= 1'b0;
    end else begin
      if (en[0]) f_vld_q[0] <= pix_i.valid;
      if (en[1]) f_vld_q[1] <= f_vld_q[0];
      if (en[TF]) t_vld_q[0] <= div_vld[QW-1];
      for (int k = 1; k < NS - TF - 1; k++) begin
        if (en[TF+k]) t_vld_q[k] <= t_vld_q[k-1];
      end
      if (en[NS-1]) o_vld_q <= t_vld_q[NS-TF-2];
    end
  end

  // front 1: max, min, sector choice, step product
  logic [CW-1:0]            mx_d, mn_d, pos_d, neg_d;
  rhr_pkg::max_chan_e       base_d;
  logic signed [SW-1:0]     x_d;
  logic [CW-1:0]            f1_mx_q, f1_dl_q, f1_ad_q;
  logic                     f1_ng_q;
  rhr_pkg::max_chan_e       f1_base_q;
  logic [SW-1:0]            f1_x_q;

  always_comb begin
    mx_d = pix_i.in_red;
    mn_d = pix_i.in_red;
    if (pix_i.in_green > mx_d) mx_d = pix_i.in_green;
    if (pix_i.in_blue > mx_d) mx_d = pix_i.in_blue;
    if (pix_i.in_green < mn_d) mn_d = pix_i.in_green;
    if (pix_i.in_blue < mn_d) mn_d = pix_i.in_blue;
    if (pix_i.in_red >= pix_i.in_green && pix_i.in_red >= pix_i.in_blue) begin
      base_d = rhr_pkg::MAX_RED;
      pos_d  = pix_i.in_green;
      neg_d  = pix_i.in_blue;
    end else if (pix_i.in_green >= pix_i.in_blue) begin
      base_d = rhr_pkg::MAX_GREEN;
      pos_d  = pix_i.in_blue;
      neg_d  = pix_i.in_red;
    end else begin
      base_d = rhr_pkg::MAX_BLUE;
      pos_d  = pix_i.in_red;
      neg_d  = pix_i.in_green;
    end
    x_d = SW'($signed(pix_i.hue_steps)) * SW'($signed({1'b0, hsd_q}));
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      f1_mx_q   <= mx_d;
      f1_dl_q   <= mx_d - mn_d;
      f1_ng_q   <= pos_d < neg_d;
      f1_ad_q   <= (pos_d < neg_d) ? neg_d - pos_d : pos_d - neg_d;
      f1_base_q <= base_d;
      f1_x_q    <= x_d;
    end
  end

  // front 2: dividends and divisors
  logic [rhr_pkg::DivLanes-1:0][NW-1:0] f2_num_q;
  logic [rhr_pkg::DivLanes-1:0][CW-1:0] f2_den_q;
  logic [rhr_pkg::DivPayW-1:0]          f2_pay_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      f2_num_q[0] <= NW'(f1_dl_q) * NW'(rhr_pkg::CMax) + NW'(f1_mx_q >> 1);
      f2_num_q[1] <= NW'(f1_ad_q) * NW'(rhr_pkg::SectorUnit) + NW'(f1_dl_q >> 1);
      f2_den_q[0] <= (f1_mx_q == '0) ? CW'(1) : f1_mx_q;
      f2_den_q[1] <= (f1_dl_q == '0) ? CW'(1) : f1_dl_q;
      f2_pay_q    <= {f1_mx_q, f1_base_q, f1_ng_q, f1_x_q};
    end
  end

  // saturation and hue fraction
  logic [rhr_pkg::DivLanes-1:0][QW-1:0] quo;
  logic [rhr_pkg::DivPayW-1:0]          dpay;

  rhr_div #(
    .DW    (rhr_pkg::DivDenW),
    .QW    (QW),
    .PW    (rhr_pkg::DivPayW),
    .LANES (rhr_pkg::DivLanes)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_vld_q[1]),
    .en_i    (en[TF-1:DF]),
    .num_i   (f2_num_q),
    .den_i   (f2_den_q),
    .pay_i   (f2_pay_q),
    .vld_o   (div_vld),
    .quo_o   (quo),
    .pay_o   (dpay)
  );

  // tail 1: signed hue, step reduction estimate
  logic [CW-1:0]        dp_v;
  logic [1:0]           dp_base;
  logic                 dp_ng;
  logic [SW-1:0]        dp_x;
  logic [HW-1:0]        base_off;
  logic signed [HW+1:0] hs;
  logic [HW-1:0]        hue1_d;
  logic [SW-1:0]        y_d;
  logic [31:0]          yk;
  logic [HW-1:0]        t1_hue_q;
  logic [SW-1:0]        t1_y_q;
  logic [6:0]           t1_mq_q;
  logic [CW-1:0]        t1_s_q, t1_v_q;

  assign {dp_v, dp_base, dp_ng, dp_x} = dpay;

  always_comb begin
    case (dp_base)
      rhr_pkg::MAX_RED:   base_off = '0;
      rhr_pkg::MAX_GREEN: base_off = HW'(2) * HW'(rhr_pkg::SectorUnit);
      rhr_pkg::MAX_BLUE:  base_off = HW'(4) * HW'(rhr_pkg::SectorUnit);
      default:            base_off = '0;
    endcase
    if (dp_ng) begin
      hs = $signed((HW+2)'(base_off)) - $signed((HW+2)'(quo[1]));
    end else begin
      hs = $signed((HW+2)'(base_off)) + $signed((HW+2)'(quo[1]));
    end
    hue1_d = hs[HW+1] ? HW'(hs + $signed((HW+2)'(rhr_pkg::FullTurn))) : HW'(hs);
    y_d    = dp_x + rhr_pkg::ShiftBias;
    yk     = 32'(y_d) * 32'(rhr_pkg::Recip360);
  end

  always_ff @(posedge clk_i) begin
    if (en[TF]) begin
      t1_hue_q <= hue1_d;
      t1_y_q   <= y_d;
      t1_mq_q  <= yk[30:24];
      t1_s_q   <= quo[0][CW-1:0];
      t1_v_q   <= dp_v;
    end
  end

  // tail 2: step angle modulo 360
  logic [SW-1:0]  m0;
  logic [8:0]     t2_m_q;
  logic [HW-1:0]  t2_hue_q;
  logic [CW-1:0]  t2_s_q, t2_v_q;

  assign m0 = t1_y_q - SW'(t1_mq_q) * SW'(rhr_pkg::Degrees360);

  always_ff @(posedge clk_i) begin
    if (en[TF+1]) begin
      t2_m_q   <= (m0 >= SW'(rhr_pkg::Degrees360)) ? 9'(m0 - SW'(rhr_pkg::Degrees360))
                                                   : 9'(m0);
      t2_hue_q <= t1_hue_q;
      t2_s_q   <= t1_s_q;
      t2_v_q   <= t1_v_q;
    end
  end

  // tail 3: rotated hue
  logic [HW:0]    hr;
  logic [HW-1:0]  t3_hue_q;
  logic [CW-1:0]  t3_s_q, t3_v_q;

  assign hr = (HW+1)'(t2_hue_q) + ((HW+1)'(t2_m_q) << 6);

  always_ff @(posedge clk_i) begin
    if (en[TF+2]) begin
      t3_hue_q <= (hr >= (HW+1)'(rhr_pkg::FullTurn))
                  ? HW'(hr - (HW+1)'(rhr_pkg::FullTurn)) : HW'(hr);
      t3_s_q   <= t2_s_q;
      t3_v_q   <= t2_v_q;
    end
  end

  // tail 4: sector and offset within it
  logic [2:0]     sec_d;
  logic [HW-1:0]  fo;
  logic [2:0]     t4_sec_q;
  logic [FW-1:0]  t4_f_q;
  logic [CW-1:0]  t4_s_q, t4_v_q;

  always_comb begin
    sec_d = '0;
    for (int k = 1; k < 6; k++) begin
      if (t3_hue_q >= HW'(k) * HW'(rhr_pkg::SectorUnit)) sec_d = 3'(k);
    end
    fo = t3_hue_q - HW'(sec_d) * HW'(rhr_pkg::SectorUnit);
  end

  always_ff @(posedge clk_i) begin
    if (en[TF+3]) begin
      t4_sec_q <= sec_d;
      t4_f_q   <= fo[FW-1:0];
      t4_s_q   <= t3_s_q;
      t4_v_q   <= t3_v_q;
    end
  end

  // tail 5: saturation products
  logic [19:0]    t5_sf_q, t5_sg_q;
  logic [15:0]    t5_pp_q;
  logic [2:0]     t5_sec_q;
  logic [CW-1:0]  t5_v_q;

  always_ff @(posedge clk_i) begin
    if (en[TF+4]) begin
      t5_sf_q  <= 20'(t4_s_q) * 20'(t4_f_q);
      t5_sg_q  <= 20'(t4_s_q) * 20'(rhr_pkg::SectorUnit - t4_f_q);
      t5_pp_q  <= 16'(t4_v_q) * 16'(rhr_pkg::CMax - t4_s_q);
      t5_sec_q <= t4_sec_q;
      t5_v_q   <= t4_v_q;
    end
  end

  // tail 6: rounded numerators
  logic [27:0]    t6_aq_q, t6_at_q;
  logic [16:0]    t6_ap_q;
  logic [2:0]     t6_sec_q;
  logic [CW-1:0]  t6_v_q;

  always_ff @(posedge clk_i) begin
    if (en[TF+5]) begin
      t6_aq_q  <= 28'(t5_v_q) * 28'(rhr_pkg::PqtDen - t5_sf_q) + 28'(rhr_pkg::PqtHalf);
      t6_at_q  <= 28'(t5_v_q) * 28'(rhr_pkg::PqtDen - t5_sg_q) + 28'(rhr_pkg::PqtHalf);
      t6_ap_q  <= 17'(t5_pp_q) + 17'(rhr_pkg::CMax >> 1);
      t6_sec_q <= t5_sec_q;
      t6_v_q   <= t5_v_q;
    end
  end

  // tail 7: division by constants through reciprocals
  logic [40:0]    pq, pt;
  logic [34:0]    pp;
  logic [CW-1:0]  t7_p_q, t7_q_q, t7_t_q, t7_v_q;
  logic [2:0]     t7_sec_q;

  assign pq = 41'(t6_aq_q[27:8]) * 41'(rhr_pkg::RecipPqt);
  assign pt = 41'(t6_at_q[27:8]) * 41'(rhr_pkg::RecipPqt);
  assign pp = 35'(t6_ap_q) * 35'(rhr_pkg::RecipCmax);

  always_ff @(posedge clk_i) begin
    if (en[TF+6]) begin
      t7_q_q   <= pq[39:32];
      t7_t_q   <= pt[39:32];
      t7_p_q   <= pp[32:25];
      t7_sec_q <= t6_sec_q;
      t7_v_q   <= t6_v_q;
    end
  end

  // output: channel order by sector and ghost colour
  logic [CW-1:0] r_d, g_d, b_d;
  logic [CW:0]   gr_s, gg_s, gb_s;
  logic [CW-1:0] o_r_q, o_g_q, o_b_q, o_gr_q, o_gg_q, o_gb_q;

  always_comb begin
    case (t7_sec_q)
      3'd0:    begin r_d = t7_v_q; g_d = t7_t_q; b_d = t7_p_q; end
      3'd1:    begin r_d = t7_q_q; g_d = t7_v_q; b_d = t7_p_q; end
      3'd2:    begin r_d = t7_p_q; g_d = t7_v_q; b_d = t7_t_q; end
      3'd3:    begin r_d = t7_p_q; g_d = t7_q_q; b_d = t7_v_q; end
      3'd4:    begin r_d = t7_t_q; g_d = t7_p_q; b_d = t7_v_q; end
      default: begin r_d = t7_v_q; g_d = t7_p_q; b_d = t7_q_q; end
    endcase
    gr_s = {1'b0, r_d} + {1'b0, gof_q};
    gg_s = {1'b0, g_d} + {1'b0, gof_q};
    gb_s = {1'b0, b_d} + {1'b0, gof_q};
  end

  always_ff @(posedge clk_i) begin
    if (en[NS-1]) begin
      o_r_q  <= r_d;
      o_g_q  <= g_d;
      o_b_q  <= b_d;
      o_gr_q <= gr_s[CW] ? rhr_pkg::CMax : gr_s[CW-1:0];
      o_gg_q <= gg_s[CW] ? rhr_pkg::CMax : gg_s[CW-1:0];
      o_gb_q <= gb_s[CW] ? rhr_pkg::CMax : gb_s[CW-1:0];
    end
  end

  assign pix_o.valid       = o_vld_q;
  assign pix_o.out_red     = o_r_q;
  assign pix_o.out_green   = o_g_q;
  assign pix_o.out_blue    = o_b_q;
  assign pix_o.ghost_red   = o_gr_q;
  assign pix_o.ghost_green = o_gg_q;
  assign pix_o.ghost_blue  = o_gb_q;

endmodule

`default_nettype wire

@@ src/rhr_checker.sv @@
// port-level checks for rgb_hue_rotate and the bind that attaches them
// depends on assert_macros.svh and rhr_pkg
`default_nettype none
`include "assert_macros.svh"

module rhr_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      pready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [rhr_pkg::ChanW-1:0] out_red_i,
  input logic [rhr_pkg::ChanW-1:0] out_green_i,
  input logic [rhr_pkg::ChanW-1:0] out_blue_i,
  input logic [rhr_pkg::ChanW-1:0] ghost_red_i,
  input logic [rhr_pkg::ChanW-1:0] ghost_green_i,
  input logic [rhr_pkg::ChanW-1:0] ghost_blue_i
);

  logic                        ghost_ok;
  logic                        stall;
  logic [6*rhr_pkg::ChanW-1:0] out_px;

  assign ghost_ok = ghost_red_i >= out_red_i && ghost_green_i >= out_green_i
                    && ghost_blue_i >= out_blue_i;
  assign stall    = out_valid_i && !out_ready_i;
  assign out_px   = {out_red_i, out_green_i, out_blue_i,
                     ghost_red_i, ghost_green_i, ghost_blue_i};

  `RHR_ASSERT_ALWAYS(a_pready_high, pready_i, "pready dropped")
  `RHR_ASSERT(a_ghost_not_darker, out_valid_i |-> ghost_ok, "ghost colour darker than pixel")
  `RHR_ASSERT(a_out_valid_held, stall |=> out_valid_i, "result withdrawn before transaction")
  `RHR_ASSERT(a_out_data_held, stall |=> $stable(out_px), "stalled result changed")

endmodule

bind rgb_hue_rotate rhr_checker u_rhr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .pready_i      (pready),
  .out_valid_i   (pix_o.valid),
  .out_ready_i   (pix_o.ready),
  .out_red_i     (pix_o.out_red),
  .out_green_i   (pix_o.out_green),
  .out_blue_i    (pix_o.out_blue),
  .ghost_red_i   (pix_o.ghost_red),
  .ghost_green_i (pix_o.ghost_green),
  .ghost_blue_i  (pix_o.ghost_blue)
);

`default_nettype wire

@@ sim/rgb_hue_rotate_tb.sv @@
// testbench for rgb_hue_rotate: directed and random pixels against an in-bench hsv predictor
// drives the pixel channel and the apb-style register port; depends on rhr_pkg, rhr_in_if,
// rhr_out_if and the block itself
`default_nettype none

module rgb_hue_rotate_tb;

  typedef struct packed {
    logic [rhr_pkg::ChanW-1:0] red;
    logic [rhr_pkg::ChanW-1:0] green;
    logic [rhr_pkg::ChanW-1:0] blue;
    logic [rhr_pkg::StepsW-1:0] steps;
  } pixel_t;

  typedef struct packed {
    logic [rhr_pkg::ChanW-1:0] red;
    logic [rhr_pkg::ChanW-1:0] green;
    logic [rhr_pkg::ChanW-1:0] blue;
    logic [rhr_pkg::ChanW-1:0] gred;
    logic [rhr_pkg::ChanW-1:0] ggreen;
    logic [rhr_pkg::ChanW-1:0] gblue;
  } rotated_t;

  localparam longint Sec = 3840;
  localparam longint Turn = 23040;
  localparam int Limit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [rhr_pkg::AddrW-1:0] paddr = '0;
  logic [rhr_pkg::DataW-1:0] pwdata = '0;
  logic [rhr_pkg::DataW-1:0] prdata;
  logic pready;

  rhr_in_if pin();
  rhr_out_if pout();

  rgb_hue_rotate uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .pix_i(pin.sink), .pix_o(pout.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  logic [rhr_pkg::HsdW-1:0] step_deg = rhr_pkg::HsdReset;
  logic [rhr_pkg::GhostW-1:0] ghost_add = rhr_pkg::GhostReset;
  pixel_t pending_px[$];
  rotated_t awaited[$];
  int errors = 0;
  int cycles = 0;
  bit calm = 1'b0;
  int in_idle = 0, out_idle = 0;

  function automatic longint rdiv(longint num, longint den);
    return (num + den / 2) / den;
  endfunction

  function automatic longint hue_frac(longint pos, longint neg, longint dl);
    if (pos >= neg) return rdiv(Sec * (pos - neg), dl);
    return -rdiv(Sec * (neg - pos), dl);
  endfunction

  function automatic logic [rhr_pkg::ChanW-1:0] sat_ghost(longint c);
    return (c + ghost_add > 255) ? 8'd255 : 8'(c + ghost_add);
  endfunction

  function automatic rotated_t rotate_pixel(pixel_t px);
    longint r, g, b, mx, mn, dl, s, v, hue, sec, f, p, q, t, den, orr, og, ob;
    rotated_t res;
    r = px.red; g = px.green; b = px.blue;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    v = mx; dl = mx - mn; hue = 0; s = 0;
    if (mx != 0 && dl != 0) begin
      s = rdiv(dl * 255, mx);
      if (r == mx) hue = hue_frac(g, b, dl);
      else if (g == mx) hue = 2 * Sec + hue_frac(b, r, dl);
      else hue = 4 * Sec + hue_frac(r, g, dl);
      if (hue < 0) hue += Turn;
    end
    hue += longint'($signed(px.steps)) * longint'(step_deg) * 64;
    hue = hue % Turn;
    if (hue < 0) hue += Turn;
    if (s == 0) begin
      orr = v; og = v; ob = v;
    end else begin
      sec = hue / Sec; f = hue % Sec; den = 255 * Sec;
      p = rdiv(v * (255 - s), 255);
      q = rdiv(v * (den - s * f), den);
      t = rdiv(v * (den - s * (Sec - f)), den);
      case (sec)
        0: begin orr = v; og = t; ob = p; end
        1: begin orr = q; og = v; ob = p; end
        2: begin orr = p; og = v; ob = t; end
        3: begin orr = p; og = q; ob = v; end
        4: begin orr = t; og = p; ob = v; end
        default: begin orr = v; og = p; ob = q; end
      endcase
    end
    res.red = 8'(orr); res.green = 8'(og); res.blue = 8'(ob);
    res.gred = sat_ghost(orr); res.ggreen = sat_ghost(og); res.gblue = sat_ghost(ob);
    return res;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin.valid <= 1'b0;
      pin.in_red <= '0; pin.in_green <= '0; pin.in_blue <= '0; pin.hue_steps <= '0;
      in_idle <= 0;
    end else begin
      if (pin.valid && pin.ready) awaited.push_back(rotate_pixel(pending_px.pop_front()));
      if (in_idle > 0) begin
        in_idle <= in_idle - 1;
        pin.valid <= 1'b0;
      end else if (!(pin.valid && !pin.ready) && pending_px.size() > 0
                   && !calm && $urandom_range(0, 15) == 0) begin
        in_idle <= $urandom_range(1, 19) - 1;
        pin.valid <= 1'b0;
      end else if (pin.valid && pin.ready) begin
        if (pending_px.size() > 0) begin
          pin.valid <= 1'b1;
          {pin.in_red, pin.in_green, pin.in_blue, pin.hue_steps} <= pending_px[0];
        end else pin.valid <= 1'b0;
      end else if (!pin.valid && pending_px.size() > 0) begin
        pin.valid <= 1'b1;
        {pin.in_red, pin.in_green, pin.in_blue, pin.hue_steps} <= pending_px[0];
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    rotated_t exp_px;
    if (!rst_ni) begin
      pout.ready <= 1'b0;
      out_idle <= 0;
    end else begin
      cycles <= cycles + 1;
      if (pout.valid && pout.ready) begin
        if (awaited.size() == 0) begin
          $error("result with nothing expected");
          errors = errors + 1;
        end else begin
          exp_px = awaited.pop_front();
          if (pout.out_red !== exp_px.red) begin
            $error("out_red exp %0d got %0d", exp_px.red, pout.out_red); errors = errors + 1;
          end
          if (pout.out_green !== exp_px.green) begin
            $error("out_green exp %0d got %0d", exp_px.green, pout.out_green);
            errors = errors + 1;
          end
          if (pout.out_blue !== exp_px.blue) begin
            $error("out_blue exp %0d got %0d", exp_px.blue, pout.out_blue);
            errors = errors + 1;
          end
          if (pout.ghost_red !== exp_px.gred) begin
            $error("ghost_red exp %0d got %0d", exp_px.gred, pout.ghost_red);
            errors = errors + 1;
          end
          if (pout.ghost_green !== exp_px.ggreen) begin
            $error("ghost_green exp %0d got %0d", exp_px.ggreen, pout.ghost_green);
            errors = errors + 1;
          end
          if (pout.ghost_blue !== exp_px.gblue) begin
            $error("ghost_blue exp %0d got %0d", exp_px.gblue, pout.ghost_blue);
            errors = errors + 1;
          end
        end
      end
      if (out_idle > 0) begin
        out_idle <= out_idle - 1;
        pout.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        out_idle <= $urandom_range(1, 19) - 1;
        pout.ready <= 1'b0;
      end else pout.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (cycles > Limit) begin
      $display("rgb_hue_rotate_tb failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_px.size() > 0 || pin.valid || awaited.size() > 0) @(posedge clk_i);
    repeat (rhr_pkg::NumStages + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(rhr_pkg::reg_addr_e addr, logic [rhr_pkg::DataW-1:0] val);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= addr; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == rhr_pkg::REG_HUE_STEP) step_deg = val[rhr_pkg::HsdW-1:0];
    else ghost_add = val[rhr_pkg::GhostW-1:0];
    @(posedge clk_i);
  endtask

  function automatic pixel_t rand_px();
    pixel_t px;
    px = 30'($urandom);
    case ($urandom_range(0, 7))
      0: px.green = px.red;
      1: begin px.green = px.red; px.blue = px.red; end
      2: px.blue = px.green;
      3: px.steps = 6'($signed($urandom_range(0, 32)) - 16);
      default: ;
    endcase
    return px;
  endfunction

  initial begin
    pixel_t px;
    int hsd_set[6];
    int gh_set[6];
    hsd_set = '{0, 360, 511, 1, 137, 60};
    gh_set = '{0, 255, 128, 1, 26, 77};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed corner pixels at reset settings
    pending_px.push_back({8'd0, 8'd0, 8'd0, 6'd0});
    pending_px.push_back({8'd255, 8'd255, 8'd255, 6'd5});
    pending_px.push_back({8'd90, 8'd90, 8'd90, -6'sd3});
    pending_px.push_back({8'd255, 8'd0, 8'd0, 6'd0});
    pending_px.push_back({8'd0, 8'd255, 8'd0, 6'd16});
    pending_px.push_back({8'd0, 8'd0, 8'd255, -6'sd16});
    pending_px.push_back({8'd255, 8'd255, 8'd0, 6'd1});
    pending_px.push_back({8'd0, 8'd255, 8'd255, -6'sd1});
    pending_px.push_back({8'd255, 8'd0, 8'd255, 6'd10});
    pending_px.push_back({8'd255, 8'd0, 8'd1, 6'd0});
    pending_px.push_back({8'd200, 8'd100, 8'd50, 6'h1f});
    pending_px.push_back({8'd200, 8'd100, 8'd50, 6'h20});
    pending_px.push_back({8'd1, 8'd0, 8'd0, 6'h3f});
    pending_px.push_back({8'd12, 8'd200, 8'd200, 6'd7});
    wait_drained();
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(rhr_pkg::REG_HUE_STEP, hsd_set[ph]);
      write_reg(rhr_pkg::REG_GHOST, gh_set[ph]);
      if (ph == 0) begin
        write_reg(rhr_pkg::REG_HUE_STEP, 30);
        // exact hue of 360 from a pure red rotated a full turn
        pending_px.push_back({8'd255, 8'd0, 8'd0, 6'd12});
        for (int k = 0; k < 8; k++) pending_px.push_back(rand_px());
        wait_drained();
        write_reg(rhr_pkg::REG_HUE_STEP, 0);
      end
      if (ph == 5) calm = 1'b1;
      for (int k = 0; k < 130; k++) begin
        px = rand_px();
        pending_px.push_back(px);
        if (k % 20 == 19) @(posedge clk_i);
      end
      wait_drained();
    end
    if (errors == 0) begin
      $display("rgb_hue_rotate_tb passed");
    end else begin
      $display("rgb_hue_rotate_tb failed");
    end
    $finish;
  end
endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+src
src/rhr_pkg.sv
src/rhr_in_if.sv
src/rhr_out_if.sv
src/rhr_div.sv
src/rgb_hue_rotate.sv
src/rhr_checker.sv
sim/rgb_hue_rotate_tb.sv
